### design/ovle_pkg.sv
// Shared types and constants for the ordered value list engine.
// No dependencies; imported by ovle_cell and ordered_value_list_engine.
package ovle_pkg;

    // Request codes carried in req_type
    localparam logic [2:0] REQ_ADD_HEAD  = 3'd0;
    localparam logic [2:0] REQ_ADD_TAIL  = 3'd1;
    localparam logic [2:0] REQ_ADD_AFTER = 3'd2;
    localparam logic [2:0] REQ_DEL_FIRST = 3'd3;
    localparam logic [2:0] REQ_DEL_ALL   = 3'd4;
    localparam logic [2:0] REQ_DEL_HEAD  = 3'd5;
    localparam logic [2:0] REQ_READ      = 3'd6;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] match_key;
        logic signed [31:0] new_value;
    } req_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] entry_value;
        logic               list_empty;
        logic               is_last;
    } rsp_t;

    // Action applied by every cell at once
    typedef enum logic [2:0] {
        CELL_HOLD      = 3'd0,
        CELL_PUSH      = 3'd1,
        CELL_APPEND    = 3'd2,
        CELL_INS_AFTER = 3'd3,
        CELL_DEL_MATCH = 3'd4,
        CELL_POP       = 3'd5,
        CELL_ROTATE    = 3'd6
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic signed [31:0] key;
        logic signed [31:0] new_value;
    } cell_cmd_t;

    // Where a cell sits relative to the fill level
    typedef struct packed {
        logic valid;
        logic tail;
        logic last;
    } cell_pos_t;

    // Match chain passed from head towards tail
    typedef struct packed {
        logic seen;
        logic first;
    } cell_link_t;

endpackage

### design/ovle_cell.sv
// One list slot: holds a value, compares it with the key and shifts.
// Depends on ovle_pkg.
module ovle_cell (
    input  logic                clk,
    input  ovle_pkg::cell_cmd_t cmd,
    input  ovle_pkg::cell_pos_t pos,
    input  ovle_pkg::cell_link_t link_in,
    input  logic signed [31:0]  left_value,
    input  logic signed [31:0]  right_value,
    input  logic signed [31:0]  head_value,
    output ovle_pkg::cell_link_t link_out,
    output logic signed [31:0]  value
);
    import ovle_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               hit;

    assign hit            = pos.valid && (value_reg == cmd.key);
    assign link_out.seen  = link_in.seen | hit;
    assign link_out.first = hit & ~link_in.seen;
    assign value          = value_reg;

    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            CELL_HOLD:      value_next = value_reg;
            CELL_PUSH:      value_next = left_value;
            CELL_APPEND:
            begin
                if (pos.tail)
                    value_next = cmd.new_value;
            end
            CELL_INS_AFTER:
            begin
                // slot right after the first match takes the new value
                if (link_in.first)
                    value_next = cmd.new_value;
                else if (link_in.seen)
                    value_next = left_value;
            end
            CELL_DEL_MATCH:
            begin
                if (link_in.seen | hit)
                    value_next = right_value;
            end
            CELL_POP:       value_next = right_value;
            CELL_ROTATE:
            begin
                // head wraps round to the last filled slot
                if (pos.last)
                    value_next = head_value;
                else
                    value_next = right_value;
            end
            default:        value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

### design/ordered_value_list_engine.sv
// Top level of the ordered value list engine: a row of ovle_cell slots and
// the request sequencer. Depends on ovle_pkg and ovle_cell.
//
// Every request except delete-all and read out is done in the cycle it is
// taken and gives one response; all cells compare and shift in the same
// cycle. Delete-all removes one matching entry per cycle through the shared
// shift path, then responds. Read out rotates the row by one slot per cycle
// while the response register is free, emitting the head each time: one
// response per entry, leaving the list as it was. A new request is taken in
// idle once the response register is free or being emptied in the same cycle.
module ordered_value_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ovle_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ovle_pkg::rsp_t rsp
);
    import ovle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_PURGE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      left_reg, left_next;
    logic signed [31:0] key_reg, key_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    cell_cmd_t          cmd;
    cell_op_t           cell_op;
    cell_pos_t          pos [CAPACITY];
    cell_link_t         link [CAPACITY];
    logic signed [31:0] value [CAPACITY];

    logic               slot_free;
    logic               any_match;
    logic               full;
    logic               accept;
    logic               emit;
    logic               emit_status;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign any_match = link[CAPACITY-1].seen;
    assign full      = (count_reg == CW'(CAPACITY));
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cmd.op        = cell_op;
    assign cmd.key       = (state_reg == ST_IDLE) ? req.match_key : key_reg;
    assign cmd.new_value = req.new_value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] left_v;
            logic signed [31:0] right_v;
            cell_link_t         link_in;

            assign pos[gi].valid = CW'(gi) < count_reg;
            assign pos[gi].tail  = CW'(gi) == count_reg;
            assign pos[gi].last  = CW'(gi + 1) == count_reg;

            if (gi == 0)
            begin : g_head
                assign left_v  = cmd.new_value;
                assign link_in = '0;
            end
            else
            begin : g_body
                assign left_v  = value[gi-1];
                assign link_in = link[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_v = value[gi];
            end
            else
            begin : g_mid
                assign right_v = value[gi+1];
            end

            ovle_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .pos         (pos[gi]),
                .link_in     (link_in),
                .left_value  (left_v),
                .right_value (right_v),
                .head_value  (value[0]),
                .link_out    (link[gi]),
                .value       (value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        key_next       = key_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cell_op        = CELL_HOLD;
        emit           = 1'b0;
        emit_status    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = req.match_key;
                    emit     = 1'b1;
                    case (req.req_type)
                        REQ_ADD_HEAD, REQ_ADD_TAIL, REQ_ADD_AFTER:
                        begin
                            if (full)
                                emit_status = 1'b1;
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                if (req.req_type == REQ_ADD_TAIL)
                                    cell_op = CELL_APPEND;
                                else if (req.req_type == REQ_ADD_AFTER && any_match)
                                    cell_op = CELL_INS_AFTER;
                                else
                                    cell_op = CELL_PUSH;
                            end
                        end
                        REQ_DEL_FIRST:
                        begin
                            if (any_match)
                            begin
                                cell_op    = CELL_DEL_MATCH;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_DEL_ALL:
                        begin
                            emit       = 1'b0;
                            state_next = ST_PURGE;
                        end
                        REQ_DEL_HEAD:
                        begin
                            if (count_reg != '0)
                            begin
                                cell_op    = CELL_POP;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                emit                 = 1'b0;
                                rsp_valid_next       = 1'b1;
                                rsp_next.status      = 1'b0;
                                rsp_next.entry_value = '0;
                                rsp_next.list_empty  = 1'b1;
                                rsp_next.is_last     = 1'b1;
                            end
                            else
                            begin
                                emit       = 1'b0;
                                left_next  = count_reg;
                                state_next = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    cell_op              = CELL_ROTATE;
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = 1'b0;
                    rsp_next.entry_value = value[0];
                    rsp_next.list_empty  = 1'b0;
                    rsp_next.is_last     = (left_reg == CW'(1));
                    left_next            = left_reg - CW'(1);
                    if (left_reg == CW'(1))
                        state_next = ST_IDLE;
                end
            end
            ST_PURGE:
            begin
                // one match removed per cycle until none is left
                if (any_match)
                begin
                    cell_op    = CELL_DEL_MATCH;
                    count_next = count_reg - CW'(1);
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (emit)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = emit_status;
            rsp_next.entry_value = '0;
            rsp_next.list_empty  = 1'b0;
            rsp_next.is_last     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_read_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_READ && count_reg != '0) |=> state_reg == ST_READ)
        else $error("read out on a filled list did not start streaming");

    a_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> $stable(count_reg))
        else $error("entry count changed during read out");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.list_empty) |-> rsp.is_last)
        else $error("empty read response not marked last");

endmodule
